/* hw/rtl/chs_pkg.sv */
// ----------------------------------------------------------------------------
// chs_pkg
// Shared constants and types for the chained hash set.
// ----------------------------------------------------------------------------
package chs_pkg;

  localparam int NODE_COUNT_DEF  = 256;
  localparam int MAX_BUCKETS_DEF = 256;
  localparam int KEY_BITS_DEF    = 32;

  localparam int KEY_W    = 32;
  localparam int CFG_W    = 9;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 9;

  localparam logic [CFG_W-1:0] BUCKET_COUNT_RESET = 9'd251;

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_INSERT = 1'b1;

  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic head;
    logic node;
  } store_we_t;

endpackage

/* hw/rtl/chs_mod.sv */
// ----------------------------------------------------------------------------
// chs_mod
// Bit-serial remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module chs_mod #(
  parameter int KW = 32,
  parameter int BW = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [KW-1:0] dividend,
  input  logic [BW-1:0] divisor,
  output logic          done,
  output logic [BW-1:0] rem
);

  localparam int CW = $clog2(KW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [KW-1:0] quo_r, quo_nxt;
  logic [BW-1:0] rem_r, rem_nxt;
  logic [BW-1:0] div_r, div_nxt;
  logic [BW:0]   trial;
  logic [BW:0]   diff;

  assign trial = {rem_r, quo_r[KW-1]};
  assign diff  = trial - {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(KW);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = quo_r << 1;
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = diff[BW-1:0];
      end else begin
        rem_nxt = trial[BW-1:0];
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

/* hw/rtl/chs_store.sv */
// ----------------------------------------------------------------------------
// chs_store
// Bucket head table and node store (key and link), registered reads.
// ----------------------------------------------------------------------------
module chs_store #(
  parameter int NODE_COUNT  = 256,
  parameter int MAX_BUCKETS = 256,
  parameter int KW          = 32,
  parameter int NW          = 8,
  parameter int BKW         = 8
) (
  input  logic              clk,
  input  chs_pkg::store_we_t we,
  input  logic [BKW-1:0]    head_wa,
  input  logic [NW:0]       head_wd,
  input  logic [BKW-1:0]    head_ra,
  output logic [NW:0]       head_rd,
  input  logic [NW-1:0]     node_wa,
  input  logic [KW-1:0]     node_wkey,
  input  logic [NW:0]       node_wnext,
  input  logic [NW-1:0]     node_ra,
  output logic [KW-1:0]     node_rkey,
  output logic [NW:0]       node_rnext
);

  import chs_pkg::*;

  logic [NW:0]   head_mem [MAX_BUCKETS];
  logic [KW-1:0] key_mem  [NODE_COUNT];
  logic [NW:0]   next_mem [NODE_COUNT];

  always_ff @(posedge clk) begin
    if (we.head) begin
      head_mem[head_wa] <= head_wd;
    end
    head_rd <= head_mem[head_ra];
  end

  always_ff @(posedge clk) begin
    if (we.node) begin
      key_mem[node_wa]  <= node_wkey;
      next_mem[node_wa] <= node_wnext;
    end
    node_rkey  <= key_mem[node_ra];
    node_rnext <= next_mem[node_ra];
  end

endmodule

/* hw/rtl/chained_hash_set.sv */
// ----------------------------------------------------------------------------
// chained_hash_set
// Hash set of integer keys with separate chaining in a fixed node store.
//
// A request (lookup or insert) is taken when start is high and busy is low.
// The bucket is the key modulo the bucket count, worked out by a bit-serial
// remainder unit; the head table is then read and the chain is walked one
// node per cycle through the node store's single read port. The result is
// shown for exactly one cycle with out_strobe and cannot be held off, so it
// must be captured on that cycle. After reset the head table is cleared one
// bucket a cycle, with busy high; the bucket count may be written at any
// time the block is idle.
// ----------------------------------------------------------------------------
module chained_hash_set #(
  parameter int NODE_COUNT  = chs_pkg::NODE_COUNT_DEF,
  parameter int MAX_BUCKETS = chs_pkg::MAX_BUCKETS_DEF,
  parameter int KEY_BITS    = chs_pkg::KEY_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_req_type,
  input  logic [chs_pkg::KEY_W-1:0]    in_key,
  output logic                         out_strobe,
  output logic [chs_pkg::STATUS_W-1:0] out_status,
  output logic [chs_pkg::COUNT_W-1:0]  out_stored_count,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [chs_pkg::CFG_W-1:0]    cfg_data
);

  import chs_pkg::*;

  localparam int KW  = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int NW  = $clog2(NODE_COUNT);
  localparam int CW  = $clog2(NODE_COUNT + 1);
  localparam int BKW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int BW  = $clog2(MAX_BUCKETS + 1);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_MOD  = 3'd2;
  localparam logic [2:0] S_HRD  = 3'd3;
  localparam logic [2:0] S_HEAD = 3'd4;
  localparam logic [2:0] S_NODE = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic [BKW-1:0]      clr_r, clr_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [CFG_W-1:0]    bcount_r;
  logic                op_r, op_nxt;
  logic [KW-1:0]       key_r, key_nxt;
  logic [BKW-1:0]      bucket_r, bucket_nxt;
  logic [NW:0]         head_q_r, head_q_nxt;
  logic                strobe_r, strobe_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [COUNT_W-1:0]  count_out_r, count_out_nxt;
  logic                mod_busy_seen_r, mod_busy_seen_nxt;

  logic [31:0]         eff32;
  logic                mod_start;
  logic                mod_done;
  logic [BW-1:0]       mod_rem;
  logic                hit;
  logic                miss;
  logic [NW:0]         link;

  store_we_t           we;
  logic [BKW-1:0]      head_wa;
  logic [NW:0]         head_wd;
  logic [BKW-1:0]      head_ra;
  logic [NW:0]         head_rd;
  logic [NW-1:0]       node_ra;
  logic [KW-1:0]       node_rkey;
  logic [NW:0]         node_rnext;

  // effective bucket count, zero taken as one, saturated to the table size
  always_comb begin
    if (bcount_r == '0) begin
      eff32 = 32'd1;
    end else if (32'(bcount_r) > 32'(MAX_BUCKETS)) begin
      eff32 = 32'(MAX_BUCKETS);
    end else begin
      eff32 = 32'(bcount_r);
    end
  end

  chs_mod #(
    .KW (KW),
    .BW (BW)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (key_r),
    .divisor  (eff32[BW-1:0]),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  chs_store #(
    .NODE_COUNT  (NODE_COUNT),
    .MAX_BUCKETS (MAX_BUCKETS),
    .KW          (KW),
    .NW          (NW),
    .BKW         (BKW)
  ) u_store (
    .clk        (clk),
    .we         (we),
    .head_wa    (head_wa),
    .head_wd    (head_wd),
    .head_ra    (head_ra),
    .head_rd    (head_rd),
    .node_wa    (cnt_r[NW-1:0]),
    .node_wkey  (key_r),
    .node_wnext (link),
    .node_ra    (node_ra),
    .node_rkey  (node_rkey),
    .node_rnext (node_rnext)
  );

  assign link = (state_r == S_NODE) ? head_q_r : head_rd;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cnt_nxt       = cnt_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    bucket_nxt    = bucket_r;
    head_q_nxt    = head_q_r;
    strobe_nxt    = 1'b0;
    status_nxt    = status_r;
    count_out_nxt = count_out_r;
    hit           = 1'b0;
    miss          = 1'b0;
    we            = '0;
    head_wa       = bucket_r;
    head_wd       = {1'b1, cnt_r[NW-1:0]};
    head_ra       = bucket_r;
    node_ra       = '0;

    case (state_r)
      S_CLR: begin
        we.head = 1'b1;
        head_wa = clr_r;
        head_wd = '0;
        clr_nxt = clr_r + BKW'(1);
        if (clr_r == BKW'(MAX_BUCKETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          op_nxt    = in_req_type;
          key_nxt   = KW'(in_key);
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        // key register is loaded, kick the remainder unit once
        if (mod_done) begin
          bucket_nxt = BKW'(mod_rem);
          state_nxt  = S_HRD;
        end
      end
      S_HRD: begin
        state_nxt = S_HEAD;
      end
      S_HEAD: begin
        head_q_nxt = head_rd;
        if (head_rd[NW]) begin
          node_ra   = head_rd[NW-1:0];
          state_nxt = S_NODE;
        end else begin
          miss = 1'b1;
        end
      end
      S_NODE: begin
        if (node_rkey == key_r) begin
          hit = 1'b1;
        end else if (node_rnext[NW]) begin
          node_ra = node_rnext[NW-1:0];
        end else begin
          miss = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (hit) begin
      status_nxt = (op_r == REQ_INSERT) ? ST_PRESENT : ST_FOUND;
    end else if (miss) begin
      if (op_r == REQ_LOOKUP) begin
        status_nxt = ST_MISSING;
      end else if (cnt_r == CW'(NODE_COUNT)) begin
        status_nxt = ST_FULL;
      end else begin
        status_nxt = ST_INSERTED;
        we.head    = 1'b1;
        we.node    = 1'b1;
        cnt_nxt    = cnt_r + CW'(1);
      end
    end
    if (hit || miss) begin
      strobe_nxt    = 1'b1;
      count_out_nxt = COUNT_W'(cnt_nxt);
      state_nxt     = S_IDLE;
    end
  end

  // start the remainder in the cycle after the transfer, once the key is held
  always_comb begin
    mod_start = (state_r == S_MOD) && (state_nxt == S_MOD) && !mod_busy_seen_r;
  end

  always_comb begin
    mod_busy_seen_nxt = (state_r == S_MOD) && (state_nxt == S_MOD);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_CLR;
      clr_r           <= '0;
      cnt_r           <= '0;
      bcount_r        <= BUCKET_COUNT_RESET;
      strobe_r        <= 1'b0;
      mod_busy_seen_r <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      clr_r           <= clr_nxt;
      cnt_r           <= cnt_nxt;
      strobe_r        <= strobe_nxt;
      mod_busy_seen_r <= mod_busy_seen_nxt;
      if (cfg_valid && cfg_ready) begin
        bcount_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    key_r       <= key_nxt;
    bucket_r    <= bucket_nxt;
    head_q_r    <= head_q_nxt;
    status_r    <= status_nxt;
    count_out_r <= count_out_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign cfg_ready        = !busy;
  assign out_strobe       = strobe_r;
  assign out_status       = status_r;
  assign out_stored_count = count_out_r;

endmodule
